// ===== rtl/tftp_rc_pkg.sv =====
// Shared types and constants of the TFTP read client control block.
package tftp_rc_pkg;

   localparam logic [15:0] OP_DATA  = 16'd3;
   localparam logic [15:0] OP_ERROR = 16'd5;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_PACKET  = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   localparam logic [1:0] CSR_TRY_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_FULL_LEN    = 2'd1;
   localparam logic [1:0] CSR_SERVER_PORT = 2'd2;
   localparam logic [1:0] CSR_SERVER_ADDR = 2'd3;

   localparam logic [3:0]  RST_TRY_LIMIT   = 4'd5;
   localparam logic [15:0] RST_FULL_LEN    = 16'd512;
   localparam logic [15:0] RST_SERVER_PORT = 16'd69;
   localparam logic [15:0] FIRST_BLOCK     = 16'd1;

   typedef enum logic [0:0] {PHASE_IDLE, PHASE_WAIT} phase_type;

   typedef enum logic [1:0] {KIND_NONE, KIND_RRQ, KIND_ACK} kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WAIT, ST_DONE, ST_TIMEOUT, ST_SERVER_ERR, ST_UNKNOWN
   } status_type;

   typedef enum logic [2:0] {
      EV_START, EV_TIMEOUT, EV_DATA, EV_ERROR, EV_UNKNOWN, EV_NOP
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [15:0]    blk;
      logic [15:0]    data_len;
      logic [15:0]    src_port;
   } event_type;

   typedef struct packed {
      kind_type    send_kind;
      logic [15:0] send_block;
      logic [15:0] send_port;
      logic [31:0] send_addr;
      logic        deliver;
      logic [15:0] deliver_len;
      status_type  status;
      logic [15:0] error_code;
   } result_type;

endpackage

// ===== rtl/tftp_rc_front.sv =====
// Front end: accepts request transactions and classifies them into events.
module tftp_rc_front
   import tftp_rc_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_pkt_opcode,
   input  logic [15:0] req_pkt_block,
   input  logic [15:0] req_pkt_data_len,
   input  logic [15:0] req_pkt_src_port,
   input  logic        q_full,
   output logic        q_push,
   output event_type   q_event
);

   event_kind_type kind;

   always_comb begin
      case (req_command)
         CMD_START: begin
            kind = EV_START;
         end
         CMD_PACKET: begin
            if (req_pkt_opcode == OP_DATA) begin
               kind = EV_DATA;
            end else if (req_pkt_opcode == OP_ERROR) begin
               kind = EV_ERROR;
            end else begin
               kind = EV_UNKNOWN;
            end
         end
         CMD_TIMEOUT: begin
            kind = EV_TIMEOUT;
         end
         default: begin
            kind = EV_NOP;
         end
      endcase
   end

   assign req_ready        = !q_full;
   assign q_push           = req_valid && !q_full;
   assign q_event.kind     = kind;
   assign q_event.blk      = req_pkt_block;
   assign q_event.data_len = req_pkt_data_len;
   assign q_event.src_port = req_pkt_src_port;

endmodule

// ===== rtl/tftp_rc_queue.sv =====
// Short event queue between the front end and the back end.
module tftp_rc_queue
   import tftp_rc_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output event_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   event_type         mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/tftp_rc_back.sv =====
// Back end: transfer state, configuration registers and the response register.
module tftp_rc_back
   import tftp_rc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        q_not_empty,
   input  event_type   q_event,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp_result
);

   logic [3:0]  try_limit_ff;
   logic [15:0] full_len_ff;
   logic [15:0] server_port_ff;
   logic [31:0] server_addr_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] exp_block_ff, exp_block_in;
   logic [3:0]  try_count_ff, try_count_in;
   kind_type    last_kind_ff, last_kind_in;
   logic [15:0] last_ack_ff, last_ack_in;
   logic [15:0] peer_port_ff, peer_port_in;
   logic        rsp_valid_ff;
   result_type  rsp_ff, rsp_in;

   logic fire;
   logic in_wait;
   logic can_retry;
   logic first_ok;
   logic block_match;
   logic short_block;

   assign fire        = q_not_empty && (!rsp_valid_ff || rsp_ready);
   assign q_pop       = fire;
   assign in_wait     = (phase_ff == PHASE_WAIT);
   assign can_retry   = (try_count_ff < try_limit_ff);
   assign first_ok    = (try_limit_ff != 4'd0);
   assign block_match = (q_event.blk == exp_block_ff);
   assign short_block = (q_event.data_len < full_len_ff);

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (q_event.kind)
            EV_START: begin
               phase_in = first_ok ? PHASE_WAIT : PHASE_IDLE;
            end
            EV_TIMEOUT: begin
               if (in_wait && !can_retry) begin
                  phase_in = PHASE_IDLE;
               end
            end
            EV_DATA: begin
               if (in_wait) begin
                  if (block_match) begin
                     if (short_block || !first_ok) begin
                        phase_in = PHASE_IDLE;
                     end
                  end else if (!can_retry) begin
                     phase_in = PHASE_IDLE;
                  end
               end
            end
            EV_ERROR, EV_UNKNOWN: begin
               phase_in = PHASE_IDLE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      exp_block_in = exp_block_ff;
      try_count_in = try_count_ff;
      last_kind_in = last_kind_ff;
      last_ack_in  = last_ack_ff;
      peer_port_in = peer_port_ff;
      rsp_in       = '0;
      rsp_in.status = in_wait ? ST_WAIT : ST_IDLE;
      if (fire) begin
         case (q_event.kind)
            EV_START: begin
               exp_block_in = FIRST_BLOCK;
               try_count_in = 4'd0;
               last_kind_in = KIND_RRQ;
               last_ack_in  = 16'd0;
               peer_port_in = server_port_ff;
               if (first_ok) begin
                  try_count_in        = 4'd1;
                  rsp_in.send_kind    = KIND_RRQ;
                  rsp_in.send_port    = server_port_ff;
                  rsp_in.send_addr    = server_addr_ff;
                  rsp_in.status       = ST_WAIT;
               end else begin
                  rsp_in.status = ST_TIMEOUT;
               end
            end
            EV_TIMEOUT, EV_DATA: begin
               if (in_wait) begin
                  if (q_event.kind == EV_DATA && block_match) begin
                     rsp_in.deliver     = 1'b1;
                     rsp_in.deliver_len = q_event.data_len;
                     peer_port_in       = q_event.src_port;
                     last_kind_in       = KIND_ACK;
                     last_ack_in        = q_event.blk;
                     exp_block_in       = exp_block_ff + 16'd1;
                     try_count_in       = 4'd0;
                     if (short_block || first_ok) begin
                        rsp_in.send_kind  = KIND_ACK;
                        rsp_in.send_block = q_event.blk;
                        rsp_in.send_port  = q_event.src_port;
                        rsp_in.send_addr  = server_addr_ff;
                     end
                     if (short_block) begin
                        rsp_in.status = ST_DONE;
                     end else if (first_ok) begin
                        try_count_in  = 4'd1;
                        rsp_in.status = ST_WAIT;
                     end else begin
                        rsp_in.status = ST_TIMEOUT;
                     end
                  end else if (can_retry) begin
                     try_count_in      = try_count_ff + 4'd1;
                     rsp_in.send_kind  = last_kind_ff;
                     rsp_in.send_block = (last_kind_ff == KIND_ACK) ? last_ack_ff : 16'd0;
                     rsp_in.send_port  = peer_port_ff;
                     rsp_in.send_addr  = server_addr_ff;
                     rsp_in.status     = ST_WAIT;
                  end else begin
                     rsp_in.status = ST_TIMEOUT;
                  end
               end
            end
            EV_ERROR: begin
               if (in_wait) begin
                  rsp_in.status     = ST_SERVER_ERR;
                  rsp_in.error_code = q_event.blk;
               end
            end
            EV_UNKNOWN: begin
               if (in_wait) begin
                  rsp_in.status = ST_UNKNOWN;
               end
            end
            default: begin
               rsp_in.status = in_wait ? ST_WAIT : ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         try_limit_ff   <= RST_TRY_LIMIT;
         full_len_ff    <= RST_FULL_LEN;
         server_port_ff <= RST_SERVER_PORT;
         server_addr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRY_LIMIT:   try_limit_ff   <= csr_wdata[3:0];
            CSR_FULL_LEN:    full_len_ff    <= csr_wdata[15:0];
            CSR_SERVER_PORT: server_port_ff <= csr_wdata[15:0];
            CSR_SERVER_ADDR: server_addr_ff <= csr_wdata;
            default: begin
               try_limit_ff <= try_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         exp_block_ff <= FIRST_BLOCK;
         try_count_ff <= 4'd0;
         last_kind_ff <= KIND_NONE;
         last_ack_ff  <= 16'd0;
         peer_port_ff <= RST_SERVER_PORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         exp_block_ff <= exp_block_in;
         try_count_ff <= try_count_in;
         last_kind_ff <= last_kind_in;
         last_ack_ff  <= last_ack_in;
         peer_port_ff <= peer_port_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

// ===== rtl/tftp_read_client_fsm_top.sv =====
// Top level of the TFTP read client control block.
// An accepted request transaction is written into the event queue; the back end then registers its response.
// One transaction is taken every cycle while the response side keeps up.
// The front end feeds a short event queue; the back end decides one event per cycle while the response side keeps up.
// Reset is synchronous and active high; it restores the default configuration.
// After reset the block is idle and ready in the next cycle.
module tftp_read_client_fsm_top
   import tftp_rc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_pkt_opcode,
   input  logic [15:0] req_pkt_block,
   input  logic [15:0] req_pkt_data_len,
   input  logic [15:0] req_pkt_src_port,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_send_kind,
   output logic [15:0] rsp_send_block,
   output logic [15:0] rsp_send_port,
   output logic [31:0] rsp_send_addr,
   output logic        rsp_deliver,
   output logic [15:0] rsp_deliver_len,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_error_code
);

   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_not_empty;
   event_type  push_event;
   event_type  pop_event;
   result_type result;

   tftp_rc_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_pkt_opcode   (req_pkt_opcode),
      .req_pkt_block    (req_pkt_block),
      .req_pkt_data_len (req_pkt_data_len),
      .req_pkt_src_port (req_pkt_src_port),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_event          (push_event)
   );

   tftp_rc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_event),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_event)
   );

   tftp_rc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_not_empty (q_not_empty),
      .q_event     (pop_event),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (result)
   );

   assign rsp_send_kind   = result.send_kind;
   assign rsp_send_block  = result.send_block;
   assign rsp_send_port   = result.send_port;
   assign rsp_send_addr   = result.send_addr;
   assign rsp_deliver     = result.deliver;
   assign rsp_deliver_len = result.deliver_len;
   assign rsp_status      = result.status;
   assign rsp_error_code  = result.error_code;

endmodule

// ===== rtl/tftp_rc_checker.sv =====
// Port-level checks of the TFTP read client control block and their binding.
module tftp_rc_checker
   import tftp_rc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_send_kind,
   input logic [15:0] rsp_send_block,
   input logic [15:0] rsp_send_port,
   input logic [31:0] rsp_send_addr,
   input logic        rsp_deliver,
   input logic [15:0] rsp_deliver_len,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_error_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("A stalled response transaction was withdrawn.");

   a_no_send_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind == KIND_NONE |->
         rsp_send_block == 16'd0 && rsp_send_port == 16'd0 && rsp_send_addr == 32'd0)
      else $error("Send fields are set without a send order.");

   a_rrq_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind == KIND_RRQ |-> rsp_send_block == 16'd0)
      else $error("A read request carries a block number.");

   a_deliver_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_deliver |-> rsp_deliver_len == 16'd0)
      else $error("A length is reported without a delivery.");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_SERVER_ERR |-> rsp_error_code == 16'd0)
      else $error("An error code is reported without a server error.");

endmodule

bind tftp_read_client_fsm_top tftp_rc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_send_kind   (rsp_send_kind),
   .rsp_send_block  (rsp_send_block),
   .rsp_send_port   (rsp_send_port),
   .rsp_send_addr   (rsp_send_addr),
   .rsp_deliver     (rsp_deliver),
   .rsp_deliver_len (rsp_deliver_len),
   .rsp_status      (rsp_status),
   .rsp_error_code  (rsp_error_code)
);
